FILE: hdl/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// shared constants, types and character helpers of the percent-escape decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ped_pkg;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   localparam logic MODE_WEB      = 1'b0;
   localparam logic MODE_SETTINGS = 1'b1;

   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       eos;
      logic       last;
   } result_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic r;
      r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
          ((c >= 8'h41) && (c <= 8'h46));
      return r;
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         t = c - 8'h30;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         t = c - 8'h57;
      end else begin
         t = c - 8'h37;
      end
      return t[3:0];
   endfunction

   function automatic logic is_break(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/percent_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder_unit
// percent-escape text decoder with web and settings-file modes
//
//   channel   dir  data                      side band
//   req_      in   tdata[7:0] char_byte      tlast end_of_text
//   rsp_      out  tdata[7:0] out_byte       tuser[0] byte_valid,
//                                            tuser[1] end_of_string,
//                                            tlast last_in_run
//   csr_      in   wr_data[0] decode_mode    wr_en write strobe
//
// an item is registered, then decoded combinationally into up to three results
// held in a small shift buffer that drains one result per cycle unless stalled
// input throughput is one item per cycle when each item gives at most one
// result and rsp is not stalled; more results per item hold the input at the buffer
// synchronous active-high reset clears escape state, buffer and mode
// a stalled rsp side backs up into the input register and then req_tready
// ----------------------------------------------------------------------------
`default_nettype none

module percent_escape_decoder_unit
   import ped_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // char_byte
   input  wire logic       req_tlast,   // end_of_text
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // out_byte
   output      logic [1:0] rsp_tuser,   // byte_valid, end_of_string
   output      logic       rsp_tlast,   // last_in_run
   input  wire logic       csr_wr_en,
   input  wire logic [0:0] csr_wr_data
);

   logic                   mode_ff;
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_term_ff;
   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             held_ff, held_in;
   logic [7:0]             last_sent_ff, last_sent_in;
   result_type             slot_ff [MAX_RESULTS];
   logic [1:0]             cnt_ff;

   logic                   rsp_fire;
   logic                   buf_free;
   logic                   advance;

   logic                   e0, e1, e2;
   result_type             r0, r1, r2;
   result_type             n0, n1, n2;
   logic [1:0]             n_cnt;
   logic                   plain_en;
   logic [7:0]             plain_byte;
   logic                   plain_pct;
   logic [7:0]             dec_val;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign buf_free   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign advance    = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot_ff[0].data;
   assign rsp_tuser  = {slot_ff[0].eos, slot_ff[0].valid};
   assign rsp_tlast  = slot_ff[0].last;

   assign dec_val = {hex_val(held_ff), hex_val(in_char_ff)};

   // plain handling of the current byte
   always_comb begin
      plain_pct  = (in_char_ff == CHAR_PERCENT);
      plain_en   = !plain_pct;
      plain_byte = ((mode_ff == MODE_WEB) && (in_char_ff == CHAR_PLUS)) ? CHAR_SPACE
                                                                         : in_char_ff;
   end

   // decode: up to a percent, a held digit and one tail result
   always_comb begin
      e0 = 1'b0;
      e1 = 1'b0;
      e2 = 1'b0;
      r0 = '{data: CHAR_PERCENT, valid: 1'b1, eos: 1'b0, last: 1'b0};
      r1 = '{data: held_ff, valid: 1'b1, eos: 1'b0, last: 1'b0};
      r2 = '{data: plain_byte, valid: 1'b1, eos: 1'b0, last: 1'b0};
      phase_in = 2'd0;
      held_in  = held_ff;
      if (in_term_ff) begin
         e0 = (phase_ff == 2'd1) || (phase_ff == 2'd2);
         e1 = (phase_ff == 2'd2);
         e2 = 1'b1;
         r2 = '{data: 8'h00, valid: 1'b0, eos: 1'b1, last: 1'b0};
         held_in = 8'h00;
      end else if (phase_ff == 2'd1) begin
         if (plain_pct) begin
            e0 = 1'b1;
         end else if (is_hex(in_char_ff)) begin
            held_in  = in_char_ff;
            phase_in = 2'd2;
         end else begin
            e0 = 1'b1;
            e2 = plain_en;
         end
      end else if (phase_ff == 2'd2) begin
         held_in = 8'h00;
         if (is_hex(in_char_ff) && is_hex(held_ff)) begin
            e2 = !((mode_ff == MODE_SETTINGS) && is_break(dec_val) &&
                   is_break(last_sent_ff));
            r2.data = dec_val;
         end else begin
            e0 = 1'b1;
            e1 = 1'b1;
            e2 = plain_en;
            if (plain_pct) begin
               phase_in = 2'd1;
            end
         end
      end else begin
         e2 = plain_en;
         if (plain_pct) begin
            phase_in = 2'd1;
         end
      end

      if (in_term_ff) begin
         last_sent_in = 8'h00;
      end else if (e2) begin
         last_sent_in = r2.data;
      end else if (e1) begin
         last_sent_in = r1.data;
      end else if (e0) begin
         last_sent_in = r0.data;
      end else begin
         last_sent_in = last_sent_ff;
      end

      n_cnt = 2'({1'b0, e0} + {1'b0, e1} + {1'b0, e2});
      n0 = e0 ? r0 : r2;
      n1 = e1 ? r1 : r2;
      n2 = r2;
      n0.last = (n_cnt == 2'd1);
      n1.last = (n_cnt == 2'd2);
      n2.last = (n_cnt == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WEB;
         in_valid_ff  <= 1'b0;
         phase_ff     <= 2'd0;
         held_ff      <= 8'h00;
         last_sent_ff <= 8'h00;
         cnt_ff       <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data[0];
         end
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            held_ff      <= held_in;
            last_sent_ff <= last_sent_in;
            cnt_ff       <= n_cnt;
         end else if (rsp_fire) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_tdata;
         in_term_ff <= req_tlast;
      end
      if (advance) begin
         slot_ff[0] <= n0;
         slot_ff[1] <= n1;
         slot_ff[2] <= n2;
      end else if (rsp_fire) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   a_tready_buffer: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (cnt_ff > 2'd1)) |-> !req_tready)
      else $error("input taken while result buffer still busy");

   a_eos_is_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (!rsp_tuser[0] && rsp_tlast))
      else $error("end of string result carries a byte or is not last");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == 2'd2) |-> is_hex(held_ff))
      else $error("escape pending without a held hex digit");

endmodule

`default_nettype wire

FILE: tb/percent_escape_decoder_checker.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder_checker
// watches the req, rsp and csr ports of the percent-escape decoder, predicts
// the decoded results of every accepted item and compares them field by field
// in arrival order; reports the failure count and the results still owed
// ----------------------------------------------------------------------------
module percent_escape_decoder_checker
   import ped_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,
   input  wire logic [1:0] rsp_tuser,
   input  wire logic       rsp_tlast,
   input  wire logic       csr_wr_en,
   input  wire logic [0:0] csr_wr_data,
   output int              fail_count,
   output int              outstanding,
   output int              results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {PH_IDLE, PH_PERCENT, PH_DIGIT} escape_phase_type;

   logic             decode_mode = MODE_WEB;
   escape_phase_type phase = PH_IDLE;
   logic [7:0]       held_char = 8'h00;
   logic [7:0]       last_out = 8'h00;
   result_type       step_out [MAX_RESULTS];
   int unsigned      step_count = 0;
   result_type       decoded_queue [$];
   int               errors = 0;
   int               seen = 0;

   // {is hex digit, nibble value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, c[3:0]};
      end
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         return {1'b1, c[3:0] + 4'd9};
      end
      return 5'd0;
   endfunction

   function automatic logic is_line_break(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic void put_out(input logic [7:0] b, input logic v, input logic e);
      step_out[step_count] = '{data: b, valid: v, eos: e, last: 1'b0};
      step_count++;
   endfunction

   function automatic void send_char(input logic [7:0] b);
      put_out(b, 1'b1, 1'b0);
      last_out = b;
   endfunction

   function automatic void plain_char(input logic [7:0] c);
      if (c == CHAR_PERCENT) begin
         phase = PH_PERCENT;
      end else if (decode_mode == MODE_WEB && c == CHAR_PLUS) begin
         send_char(CHAR_SPACE);
      end else begin
         send_char(c);
      end
   endfunction

   function automatic void decode_item(input logic [7:0] c, input logic term);
      logic [4:0] lo;
      logic [4:0] hi;
      logic [7:0] v;
      result_type r;
      step_count = 0;
      lo = hex_nibble(c);
      if (term) begin
         if (phase == PH_PERCENT) begin
            send_char(CHAR_PERCENT);
         end else if (phase == PH_DIGIT) begin
            send_char(CHAR_PERCENT);
            send_char(held_char);
         end
         put_out(8'h00, 1'b0, 1'b1);
         phase = PH_IDLE;
         held_char = 8'h00;
         last_out = 8'h00;
      end else if (phase == PH_PERCENT) begin
         phase = PH_IDLE;
         if (c == CHAR_PERCENT) begin
            send_char(CHAR_PERCENT);
         end else if (lo[4]) begin
            held_char = c;
            phase = PH_DIGIT;
         end else begin
            send_char(CHAR_PERCENT);
            plain_char(c);
         end
      end else if (phase == PH_DIGIT) begin
         hi = hex_nibble(held_char);
         phase = PH_IDLE;
         if (lo[4] && hi[4]) begin
            v = {hi[3:0], lo[3:0]};
            if (!(decode_mode == MODE_SETTINGS && is_line_break(v) &&
                  is_line_break(last_out))) begin
               send_char(v);
            end
         end else begin
            send_char(CHAR_PERCENT);
            send_char(held_char);
            plain_char(c);
         end
         held_char = 8'h00;
      end else begin
         phase = PH_IDLE;
         plain_char(c);
      end
      for (int unsigned i = 0; i < step_count; i++) begin
         r = step_out[i];
         r.last = (i == step_count - 1);
         decoded_queue.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task automatic check_result();
      result_type want;
      if (decoded_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected result, out_byte %02h", rsp_tdata));
         return;
      end
      want = decoded_queue.pop_front();
      if (rsp_tdata != want.data) begin
         report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                   seen, rsp_tdata, want.data));
      end
      if (rsp_tuser[0] != want.valid) begin
         report_mismatch($sformatf("result %0d byte_valid %0b, expected %0b",
                                   seen, rsp_tuser[0], want.valid));
      end
      if (rsp_tuser[1] != want.eos) begin
         report_mismatch($sformatf("result %0d end_of_string %0b, expected %0b",
                                   seen, rsp_tuser[1], want.eos));
      end
      if (rsp_tlast != want.last) begin
         report_mismatch($sformatf("result %0d last_in_run %0b, expected %0b",
                                   seen, rsp_tlast, want.last));
      end
      seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decode_mode = MODE_WEB;
         phase = PH_IDLE;
         held_char = 8'h00;
         last_out = 8'h00;
         decoded_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (req_tvalid && req_tready) begin
            decode_item(req_tdata, req_tlast);
         end
         if (csr_wr_en) begin
            decode_mode = csr_wr_data[0];
         end
      end
      fail_count   <= errors;
      outstanding  <= decoded_queue.size();
      results_seen <= seen;
   end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the percent-escape decoder with directed escape cases and random
// well-formed, broken and noisy text in both decode modes, with random gaps
// and back-pressure; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module testbench
   import ped_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_wr_en = 1'b0;
   logic [0:0] csr_wr_data = 1'b0;
   logic       quiet = 1'b0;
   int         failures;
   int         outstanding;
   int         results_checked;
   int         items_sent = 0;

   percent_escape_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   percent_escape_decoder_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (failures),
      .outstanding  (outstanding),
      .results_seen (results_checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 12);
   end

   initial begin
      #400us;
      $display("[percent_escape_decoder_unit] ERROR");
      $finish;
   end

   function automatic logic [7:0] hex_char();
      string digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   task automatic send_item(input logic [7:0] c, input logic term);
      while (!quiet && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= term;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], 1'b0);
      end
   endtask

   task automatic send_term();
      send_item(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic non_hex_byte(output logic [7:0] b);
      do begin
         b = 8'($urandom_range(255));
      end while (is_hex(b) || b == CHAR_PERCENT);
   endtask

   task automatic send_token();
      int         pick;
      logic [7:0] b;
      string      break_low = "aAdD";
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_item(CHAR_PERCENT, 1'b0);
         if ($urandom_range(9) < 3) begin
            send_item("0", 1'b0);
            send_item(break_low[$urandom_range(3)], 1'b0);
         end else begin
            send_item(hex_char(), 1'b0);
            send_item(hex_char(), 1'b0);
         end
      end else if (pick < 38) begin
         send_text("%%");
      end else if (pick < 45) begin
         non_hex_byte(b);
         send_item(CHAR_PERCENT, 1'b0);
         send_item(b, 1'b0);
      end else if (pick < 52) begin
         case ($urandom_range(2))
            0: b = CHAR_PLUS;
            1: b = CHAR_PERCENT;
            default: non_hex_byte(b);
         endcase
         send_item(CHAR_PERCENT, 1'b0);
         send_item(hex_char(), 1'b0);
         send_item(b, 1'b0);
      end else if (pick < 57) begin
         send_term();
      end else if (pick < 64) begin
         send_item(CHAR_PLUS, 1'b0);
      end else if (pick < 72) begin
         send_item($urandom_range(1) ? CHAR_CR : CHAR_LF, 1'b0);
      end else begin
         send_item(8'($urandom_range(255)), 1'b0);
      end
   endtask

   initial begin
      int target;
      int waited;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // web mode from reset
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("+%4a%%%g%4+%4%");
      send_term();
      // escape left open across a mode change
      send_item(CHAR_PERCENT, 1'b0);
      write_mode(MODE_SETTINGS);
      send_text("0D");
      send_item(CHAR_CR, 1'b0);
      send_text("%0a");
      send_term();

      for (int r = 0; r < 4; r++) begin
         write_mode(r[0] ? MODE_SETTINGS : MODE_WEB);
         quiet <= (r == 2);
         target = items_sent + 64;
         while (items_sent < target) begin
            send_token();
         end
      end
      quiet <= 1'b0;
      send_term();

      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);

      $display("covered %0d input items and %0d results in web and settings-file modes",
               items_sent, results_checked);
      $display("with escapes, doubled and broken percents, flushes and dropped line breaks");
      if (outstanding != 0) begin
         $display("%0d expected results never arrived", outstanding);
      end
      if (failures == 0 && outstanding == 0) begin
         $display("[percent_escape_decoder_unit] OK");
      end else begin
         $display("[percent_escape_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/ped_pkg.sv
hdl/percent_escape_decoder_unit.sv
tb/percent_escape_decoder_checker.sv
tb/testbench.sv
